// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on a rising edge, masked in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/abte_pkg.sv -----
// ----------------------------------------------------------------------------
// abte_pkg
// Shared widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package abte_pkg;

    localparam int KEY_W          = 32;
    localparam int REQ_W          = 2;
    localparam int STAT_W         = 2;
    localparam int SLOT_W         = 7;
    localparam int TREE_SLOTS_DEF = 127;

    localparam logic [REQ_W-1:0] OP_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [REQ_W-1:0] OP_DELETE = 2'd2;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE = 2'd0,
        STAT_DUP  = 2'd1,
        STAT_FULL = 2'd2,
        STAT_MISS = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        SEL_ZERO,
        SEL_CUR,
        SEL_FOUND
    } res_sel_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FIND_RD,
        S_FIND_CHK,
        S_DEL_L_RD,
        S_DEL_L_CHK,
        S_DEL_R_RD,
        S_DEL_R_CHK,
        S_WALK_RD,
        S_WALK_CHK,
        S_MOVE,
        S_LEAF,
        S_RESP
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic     clr_step;
        logic     load_req;
        logic     rd_cur;
        logic     rd_left;
        logic     rd_right;
        logic     rd_probe;
        logic     descend;
        logic     take_left;
        logic     take_right;
        logic     take_probe;
        logic     mark_found;
        logic     wr_insert;
        logic     move;
        logic     clear_leaf;
        logic     set_res;
        status_t  res_status;
        res_sel_t res_sel;
        logic     out_load;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [REQ_W-1:0] op;
        logic             cur_in_range;
        logic             left_in_range;
        logic             right_in_range;
        logic             probe_in_range;
        logic             hit_valid;
        logic             key_eq;
        logic             clr_last;
        logic             out_free;
    } stat_t;

endpackage

// ----- design/abte_ram.sv -----
// ----------------------------------------------------------------------------
// abte_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module abte_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 127
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- design/abte_ctrl.sv -----
// ----------------------------------------------------------------------------
// abte_ctrl
// Sequencer for clear pass, tree descent, delete fix-up and result handoff.
// ----------------------------------------------------------------------------
module abte_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  abte_pkg::stat_t stat,
    output logic           in_ready,
    output abte_pkg::cmd_t cmd
);

    abte_pkg::state_t state_reg, state_next;

    logic op_known;
    assign op_known = (stat.op == abte_pkg::OP_INSERT) || (stat.op == abte_pkg::OP_SEARCH) ||
                      (stat.op == abte_pkg::OP_DELETE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= abte_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            abte_pkg::S_CLEAR:
            begin
                if (stat.clr_last)
                begin
                    state_next = abte_pkg::S_IDLE;
                end
            end
            abte_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = abte_pkg::S_FIND_RD;
                end
            end
            abte_pkg::S_FIND_RD:
            begin
                if (!op_known || !stat.cur_in_range)
                begin
                    state_next = abte_pkg::S_RESP;
                end
                else
                begin
                    state_next = abte_pkg::S_FIND_CHK;
                end
            end
            abte_pkg::S_FIND_CHK:
            begin
                priority if (!stat.hit_valid)
                begin
                    state_next = abte_pkg::S_RESP;
                end
                else if (stat.key_eq)
                begin
                    state_next = (stat.op == abte_pkg::OP_DELETE) ? abte_pkg::S_DEL_L_RD
                                                                  : abte_pkg::S_RESP;
                end
                else
                begin
                    state_next = abte_pkg::S_FIND_RD;
                end
            end
            abte_pkg::S_DEL_L_RD:
            begin
                state_next = stat.left_in_range ? abte_pkg::S_DEL_L_CHK : abte_pkg::S_DEL_R_RD;
            end
            abte_pkg::S_DEL_L_CHK:
            begin
                state_next = stat.hit_valid ? abte_pkg::S_WALK_RD : abte_pkg::S_DEL_R_RD;
            end
            abte_pkg::S_DEL_R_RD:
            begin
                state_next = stat.right_in_range ? abte_pkg::S_DEL_R_CHK : abte_pkg::S_LEAF;
            end
            abte_pkg::S_DEL_R_CHK:
            begin
                state_next = stat.hit_valid ? abte_pkg::S_WALK_RD : abte_pkg::S_LEAF;
            end
            abte_pkg::S_WALK_RD:
            begin
                state_next = stat.probe_in_range ? abte_pkg::S_WALK_CHK : abte_pkg::S_MOVE;
            end
            abte_pkg::S_WALK_CHK:
            begin
                state_next = stat.hit_valid ? abte_pkg::S_WALK_RD : abte_pkg::S_MOVE;
            end
            abte_pkg::S_MOVE:
            begin
                state_next = abte_pkg::S_DEL_L_RD;
            end
            abte_pkg::S_LEAF:
            begin
                state_next = abte_pkg::S_RESP;
            end
            abte_pkg::S_RESP:
            begin
                if (stat.out_free)
                begin
                    state_next = abte_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = abte_pkg::S_CLEAR;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd            = '0;
        cmd.res_status = abte_pkg::STAT_MISS;
        cmd.res_sel    = abte_pkg::SEL_ZERO;
        in_ready       = 1'b0;
        unique case (state_reg)
            abte_pkg::S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
            end
            abte_pkg::S_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.load_req = in_valid;
            end
            abte_pkg::S_FIND_RD:
            begin
                priority if (!op_known)
                begin
                    cmd.set_res = 1'b1;
                end
                else if (!stat.cur_in_range)
                begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = (stat.op == abte_pkg::OP_INSERT) ? abte_pkg::STAT_FULL
                                                                      : abte_pkg::STAT_MISS;
                end
                else
                begin
                    cmd.rd_cur = 1'b1;
                end
            end
            abte_pkg::S_FIND_CHK:
            begin
                priority if (!stat.hit_valid)
                begin
                    cmd.set_res = 1'b1;
                    if (stat.op == abte_pkg::OP_INSERT)
                    begin
                        cmd.wr_insert  = 1'b1;
                        cmd.res_status = abte_pkg::STAT_DONE;
                        cmd.res_sel    = abte_pkg::SEL_CUR;
                    end
                end
                else if (stat.key_eq)
                begin
                    unique case (stat.op)
                        abte_pkg::OP_INSERT:
                        begin
                            cmd.set_res    = 1'b1;
                            cmd.res_status = abte_pkg::STAT_DUP;
                        end
                        abte_pkg::OP_SEARCH:
                        begin
                            cmd.set_res    = 1'b1;
                            cmd.res_status = abte_pkg::STAT_DONE;
                            cmd.res_sel    = abte_pkg::SEL_CUR;
                        end
                        default:
                        begin
                            cmd.mark_found = 1'b1;
                        end
                    endcase
                end
                else
                begin
                    cmd.descend = 1'b1;
                end
            end
            abte_pkg::S_DEL_L_RD:
            begin
                cmd.rd_left = stat.left_in_range;
            end
            abte_pkg::S_DEL_L_CHK:
            begin
                cmd.take_left = stat.hit_valid;
            end
            abte_pkg::S_DEL_R_RD:
            begin
                cmd.rd_right = stat.right_in_range;
            end
            abte_pkg::S_DEL_R_CHK:
            begin
                cmd.take_right = stat.hit_valid;
            end
            abte_pkg::S_WALK_RD:
            begin
                cmd.rd_probe = stat.probe_in_range;
            end
            abte_pkg::S_WALK_CHK:
            begin
                cmd.take_probe = stat.hit_valid;
            end
            abte_pkg::S_MOVE:
            begin
                cmd.move = 1'b1;
            end
            abte_pkg::S_LEAF:
            begin
                cmd.clear_leaf = 1'b1;
                cmd.set_res    = 1'b1;
                cmd.res_status = abte_pkg::STAT_DONE;
                cmd.res_sel    = abte_pkg::SEL_FOUND;
            end
            abte_pkg::S_RESP:
            begin
                cmd.out_load = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- design/abte_dp.sv -----
// ----------------------------------------------------------------------------
// abte_dp
// Key/valid store, walk pointers, key compare and the output register.
// ----------------------------------------------------------------------------
module abte_dp #(
    parameter int TREE_SLOTS = abte_pkg::TREE_SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  abte_pkg::cmd_t                 cmd,
    output abte_pkg::stat_t                stat,
    input  logic [abte_pkg::KEY_W-1:0]     in_key,
    input  logic [abte_pkg::REQ_W-1:0]     in_req_type,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [abte_pkg::STAT_W-1:0]    out_status,
    output logic [abte_pkg::SLOT_W-1:0]    out_slot
);

    localparam int AW = $clog2(TREE_SLOTS);        // in-range slot index
    localparam int IW = $clog2(2 * TREE_SLOTS + 1); // child index, may be past the end
    localparam int KW = abte_pkg::KEY_W;
    localparam int SW = abte_pkg::SLOT_W;

    // walk registers
    logic [KW-1:0]              key_reg, key_next;
    logic [abte_pkg::REQ_W-1:0] op_reg, op_next;
    logic [IW-1:0]              cur_reg, cur_next;
    logic [AW-1:0]              nxt_reg, nxt_next;
    logic                       dir_reg, dir_next;     // 1: probe right children
    logic [KW-1:0]              mv_key_reg, mv_key_next;
    logic [AW-1:0]              found_reg, found_next;
    logic [AW-1:0]              clr_cnt_reg, clr_cnt_next;
    logic [abte_pkg::STAT_W-1:0] res_status_reg, res_status_next;
    logic [SW-1:0]              res_slot_reg, res_slot_next;

    // output register
    logic                       out_valid_reg, out_valid_next;
    logic [abte_pkg::STAT_W-1:0] out_status_reg, out_status_next;
    logic [SW-1:0]              out_slot_reg, out_slot_next;

    // store port
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [KW:0]   wr_data, rd_data;

    logic [AW-1:0] cur_a;
    logic [IW-1:0] left_i, right_i, probe_i;
    logic [KW-1:0] rd_key;
    logic [SW+AW-1:0] cur_ext, found_ext;

    assign cur_a   = cur_reg[AW-1:0];
    assign left_i  = (IW'(cur_a) << 1) + IW'(1);
    assign right_i = (IW'(cur_a) << 1) + IW'(2);
    assign probe_i = (IW'(nxt_reg) << 1) + (dir_reg ? IW'(2) : IW'(1));
    assign rd_key  = rd_data[KW-1:0];

    assign cur_ext   = {{SW{1'b0}}, cur_a};
    assign found_ext = {{SW{1'b0}}, found_reg};

    abte_ram #(
        .WIDTH (KW + 1),
        .DEPTH (TREE_SLOTS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // store access
    always_comb
    begin
        wr_en   = cmd.clr_step | cmd.wr_insert | cmd.move | cmd.clear_leaf;
        wr_addr = cmd.clr_step ? clr_cnt_reg : cur_a;
        priority if (cmd.wr_insert)
        begin
            wr_data = {1'b1, key_reg};
        end
        else if (cmd.move)
        begin
            wr_data = {1'b1, mv_key_reg};
        end
        else
        begin
            wr_data = {1'b0, mv_key_reg};
        end

        rd_en = cmd.rd_cur | cmd.rd_left | cmd.rd_right | cmd.rd_probe;
        priority if (cmd.rd_left)
        begin
            rd_addr = left_i[AW-1:0];
        end
        else if (cmd.rd_right)
        begin
            rd_addr = right_i[AW-1:0];
        end
        else if (cmd.rd_probe)
        begin
            rd_addr = probe_i[AW-1:0];
        end
        else
        begin
            rd_addr = cur_a;
        end
    end

    // register updates
    always_comb
    begin
        key_next        = key_reg;
        op_next         = op_reg;
        cur_next        = cur_reg;
        nxt_next        = nxt_reg;
        dir_next        = dir_reg;
        mv_key_next     = mv_key_reg;
        found_next      = found_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        clr_cnt_next    = cmd.clr_step ? clr_cnt_reg + AW'(1) : clr_cnt_reg;

        if (cmd.load_req)
        begin
            key_next = in_key;
            op_next  = in_req_type;
            cur_next = '0;
        end
        if (cmd.descend)
        begin
            cur_next = ($signed(key_reg) < $signed(rd_key)) ? left_i : right_i;
        end
        if (cmd.mark_found)
        begin
            found_next = cur_a;
        end
        if (cmd.take_left)
        begin
            nxt_next    = left_i[AW-1:0];
            dir_next    = 1'b1;                    // predecessor: go right
            mv_key_next = rd_key;
        end
        if (cmd.take_right)
        begin
            nxt_next    = right_i[AW-1:0];
            dir_next    = 1'b0;                    // successor: go left
            mv_key_next = rd_key;
        end
        if (cmd.take_probe)
        begin
            nxt_next    = probe_i[AW-1:0];
            mv_key_next = rd_key;
        end
        if (cmd.move)
        begin
            cur_next = IW'(nxt_reg);
        end
        if (cmd.set_res)
        begin
            res_status_next = cmd.res_status;
            unique case (cmd.res_sel)
                abte_pkg::SEL_CUR:   res_slot_next = cur_ext[SW-1:0];
                abte_pkg::SEL_FOUND: res_slot_next = found_ext[SW-1:0];
                default:             res_slot_next = '0;
            endcase
        end
    end

    // output stage
    always_comb
    begin
        out_valid_next  = out_valid_reg & ~out_ready;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        if (cmd.out_load)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_slot_next   = res_slot_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            clr_cnt_reg   <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            clr_cnt_reg   <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        op_reg         <= op_next;
        cur_reg        <= cur_next;
        nxt_reg        <= nxt_next;
        dir_reg        <= dir_next;
        mv_key_reg     <= mv_key_next;
        found_reg      <= found_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
    end

    always_comb
    begin
        stat.op             = op_reg;
        stat.cur_in_range   = cur_reg < IW'(TREE_SLOTS);
        stat.left_in_range  = left_i < IW'(TREE_SLOTS);
        stat.right_in_range = right_i < IW'(TREE_SLOTS);
        stat.probe_in_range = probe_i < IW'(TREE_SLOTS);
        stat.hit_valid      = rd_data[KW];
        stat.key_eq         = rd_key == key_reg;
        stat.clr_last       = clr_cnt_reg == AW'(TREE_SLOTS - 1);
        stat.out_free       = ~out_valid_reg | out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_slot   = out_slot_reg;

endmodule

// ----- design/array_bst_table_engine_unit.sv -----
// ----------------------------------------------------------------------------
// array_bst_table_engine_unit
// Binary search tree of signed keys held in an implicit array (children of
// slot i at 2i+1 and 2i+2), serving insert, search and delete requests.
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata            | tuser          | beat means
//  ---------+-----+------------------+----------------+------------------------
//  s_*      | in  | [31:0] key       | [1:0] req_type | one request
//  m_*      | out | [6:0] slot, [7]0 | [1:0] status   | one result per request
//
//  Steps: take the beat, read and check each slot on the search path (read
//  only if the path runs past the end), hand over. Delete adds a read and check
//  per child or walk probe (read only if past the end), a move per key and a leaf clear.
//  Reset: a clearing pass empties one slot per cycle across all slots, s_tready low.
//  Stalls: a result waits in the output register while the next request is
//  taken; the engine holds before handoff while that register is full.
//
module array_bst_table_engine_unit #(
    parameter int TREE_SLOTS = abte_pkg::TREE_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] key
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] slot, [7] zero pad
    output logic [1:0]  m_tuser    // [1:0] status
);

    abte_pkg::cmd_t  cmd;
    abte_pkg::stat_t stat;
    logic [abte_pkg::SLOT_W-1:0] slot;

    abte_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .stat     (stat),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    abte_dp #(
        .TREE_SLOTS (TREE_SLOTS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_key      (s_tdata),
        .in_req_type (s_tuser),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_status  (m_tuser),
        .out_slot    (slot)
    );

    assign m_tdata = {1'b0, slot};

endmodule

// ----- design/abte_checker.sv -----
// ----------------------------------------------------------------------------
// abte_checker
// Port-level checks: result handoff, slot field rule, request/result balance.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module abte_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser
);

    // requests taken whose result has not left yet
    logic [1:0] pend_reg, pend_next;

    always_comb
    begin
        pend_next = pend_reg + 2'((s_tvalid && s_tready) ? 1 : 0)
                             - 2'((m_tvalid && m_tready) ? 1 : 0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
    `ASSERT_IMPLY(a_slot_zero, clk, rst_n, m_tvalid && (m_tuser != abte_pkg::STAT_DONE),
        m_tdata == 8'd0, "nonzero slot with failing status")
    `ASSERT_IMPLY(a_no_orphan, clk, rst_n, m_tvalid, pend_reg != 2'd0,
        "result without a pending request")
    `ASSERT_IMPLY(a_depth, clk, rst_n, s_tvalid && s_tready, pend_reg < 2'd2,
        "request taken with two results outstanding")

endmodule

bind array_bst_table_engine_unit abte_checker u_abte_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- tb/array_bst_table_engine_unit_test.sv -----
// ----------------------------------------------------------------------------
// array_bst_table_engine_unit_test
// Checks the array tree engine against a shadow tree of its own. Each accepted
// request is applied to the shadow copy and its expected status and slot are
// queued. Each result beat is compared with the oldest queued entry. A short
// directed run covers the corner cases. A long random run follows, with grow
// and shrink phases, with keys reused from the live tree, and with random
// gaps on both streams.
// ----------------------------------------------------------------------------
module array_bst_table_engine_unit_test;

    localparam int SLOTS = abte_pkg::TREE_SLOTS_DEF;
    // req_type 3 has no operation behind it; the engine must answer with a miss
    localparam logic [abte_pkg::REQ_W-1:0] OP_NONE = 2'd3;
    localparam int RANDOM_ITEMS  = 925;
    localparam int DRAIN_EVERY   = 150;
    localparam int PHASE_LEN     = 120;
    localparam int SETTLE_CYCLES = 200;
    localparam int CYCLE_LIMIT   = 600000;

    typedef struct packed {
        abte_pkg::status_t           status;
        logic [abte_pkg::SLOT_W-1:0] slot;
    } outcome_t;

    // Shadow tree plus the queue of results it has predicted so far.
    class tree_shadow;
        logic signed [abte_pkg::KEY_W-1:0] keys [SLOTS];
        bit                      valid [SLOTS];
        outcome_t                pending [$];
        int                      errors;
        int                      checked;
        int                      population;
        int                      peak;
        int                      tally [4][4];   // [req_type][status]

        function bit occupied(int unsigned i);
            return i < SLOTS && valid[i];
        endfunction

        function bit locate(logic signed [abte_pkg::KEY_W-1:0] k, output int unsigned at);
            int unsigned i = 0;
            while (occupied(i))
            begin
                if (keys[i] == k)
                begin
                    at = i;
                    return 1'b1;
                end
                i = (k < keys[i]) ? 2 * i + 1 : 2 * i + 2;
            end
            return 1'b0;
        endfunction

        // pull predecessor (or successor if no left child) up until a leaf empties
        function void remove_from(int unsigned cur);
            int unsigned nxt;
            while (1)
            begin
                if (occupied(2 * cur + 1))
                begin
                    nxt = 2 * cur + 1;
                    while (occupied(2 * nxt + 2))
                        nxt = 2 * nxt + 2;
                end
                else if (occupied(2 * cur + 2))
                begin
                    nxt = 2 * cur + 2;
                    while (occupied(2 * nxt + 1))
                        nxt = 2 * nxt + 1;
                end
                else
                begin
                    valid[cur] = 1'b0;
                    return;
                end
                keys[cur] = keys[nxt];
                cur = nxt;
            end
        endfunction

        function void take_request(logic [abte_pkg::REQ_W-1:0] op,
                                   logic signed [abte_pkg::KEY_W-1:0] k);
            outcome_t    res;
            int unsigned at;
            res.status = abte_pkg::STAT_MISS;
            res.slot   = '0;
            case (op)
                abte_pkg::OP_INSERT:
                begin
                    at = 0;
                    res.status = abte_pkg::STAT_FULL;
                    while (at < SLOTS)
                    begin
                        if (!valid[at])
                        begin
                            keys[at]   = k;
                            valid[at]  = 1'b1;
                            res.status = abte_pkg::STAT_DONE;
                            res.slot   = at[abte_pkg::SLOT_W-1:0];
                            population++;
                            if (population > peak)
                                peak = population;
                            break;
                        end
                        if (keys[at] == k)
                        begin
                            res.status = abte_pkg::STAT_DUP;
                            break;
                        end
                        at = (k < keys[at]) ? 2 * at + 1 : 2 * at + 2;
                    end
                end
                abte_pkg::OP_SEARCH:
                begin
                    if (locate(k, at))
                    begin
                        res.status = abte_pkg::STAT_DONE;
                        res.slot   = at[abte_pkg::SLOT_W-1:0];
                    end
                end
                abte_pkg::OP_DELETE:
                begin
                    if (locate(k, at))
                    begin
                        remove_from(at);
                        population--;
                        res.status = abte_pkg::STAT_DONE;
                        res.slot   = at[abte_pkg::SLOT_W-1:0];
                    end
                end
                default:
                begin
                end
            endcase
            tally[op][res.status]++;
            pending.push_back(res);
        endfunction

        function bit pick_stored(output logic signed [abte_pkg::KEY_W-1:0] k);
            int unsigned held [$];
            for (int i = 0; i < SLOTS; i++)
                if (valid[i])
                    held.push_back(i);
            if (held.size() == 0)
                return 1'b0;
            k = keys[held[$urandom_range(0, held.size() - 1)]];
            return 1'b1;
        endfunction

        function void flag(string what);
            errors++;
            if (errors <= 10)
                $display("ERROR: %s", what);
        endfunction

        function void check_result(logic [abte_pkg::STAT_W-1:0] st, logic [7:0] data);
            outcome_t want;
            checked++;
            if (pending.size() == 0)
            begin
                flag($sformatf("result %0d arrived with nothing outstanding: status %0d data %0h",
                               checked, st, data));
                return;
            end
            want = pending.pop_front();
            if (st !== want.status)
                flag($sformatf("result %0d status: expected %0d, got %0d",
                               checked, want.status, st));
            if (data !== {1'b0, want.slot})
                flag($sformatf("result %0d slot: expected %0d, got tdata %0h",
                               checked, want.slot, data));
        endfunction
    endclass

    logic                    clk      = 1'b0;
    logic                    rst_n    = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [31:0]             s_tdata  = '0;
    logic [1:0]              s_tuser  = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [7:0]              m_tdata;
    logic [1:0]              m_tuser;

    tree_shadow              shadow = new;
    int                      cycles = 0;

    // idle pattern state: runs of no-idle beats alternate with random gaps
    int                      tx_left = 0;
    bit                      tx_steady = 1'b0;
    int                      rx_left = 0;
    bit                      rx_steady = 1'b0;

    // ascending/descending key chains drive paths straight down one edge
    int                      chain_key = 0;
    int                      chain_step = 1;

    array_bst_table_engine_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [31:0] key
        .s_tuser  (s_tuser),    // [1:0] req_type
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [6:0] slot, [7] zero pad
        .m_tuser  (m_tuser)     // [1:0] status
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, shadow.pending.size());
            $display("FAIL");
            $finish;
        end
    end

    // result monitor: values read here are the ones before this edge
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            shadow.check_result(m_tuser, m_tdata);
    end

    function automatic int next_wait(inout int run_left, inout bit steady);
        if (run_left == 0)
        begin
            run_left = $urandom_range(8, 40);
            steady   = ($urandom_range(0, 2) == 0);
        end
        run_left--;
        return steady ? 0 : $urandom_range(0, 14);
    endfunction

    // One request beat. Called at a rising edge; returns at the accepting edge.
    task automatic send_req(logic [abte_pkg::REQ_W-1:0] op,
                            logic signed [abte_pkg::KEY_W-1:0] k);
        int gap;
        gap = next_wait(tx_left, tx_steady);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= k;
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        shadow.take_request(op, k);
    endtask

    // sender holds off until the engine has answered everything
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (shadow.pending.size() != 0)
            @(posedge clk);
    endtask

    // Search and delete mostly hit live keys; inserts sometimes repeat one.
    function automatic logic signed [abte_pkg::KEY_W-1:0] draw_key(
        logic [abte_pkg::REQ_W-1:0] op);
        logic signed [abte_pkg::KEY_W-1:0] k;
        if (op != abte_pkg::OP_INSERT && $urandom_range(0, 99) < 75 && shadow.pick_stored(k))
            return k;
        if (op == abte_pkg::OP_INSERT && $urandom_range(0, 99) < 12 && shadow.pick_stored(k))
            return k;
        case ($urandom_range(0, 3))
            0: k = $urandom;
            1: k = int'($urandom_range(0, 80)) - 40;
            2: k = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 15)
                                        : 32'h7FFF_FFFF - $urandom_range(0, 15);
            default:
            begin
                if ($urandom_range(0, 15) == 0)
                begin
                    chain_key  = $urandom;
                    chain_step = $urandom_range(0, 1) ? int'($urandom_range(1, 3))
                                                      : -int'($urandom_range(1, 3));
                end
                chain_key += chain_step;
                k = chain_key;
            end
        endcase
        return k;
    endfunction

    // result side: random stall before each beat, sometimes none for a while
    initial
    begin : result_sink
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = next_wait(rx_left, rx_steady);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    initial
    begin : stimulus
        logic [abte_pkg::REQ_W-1:0] op;
        int               roll;
        bit               grow;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty tree: both lookups miss
        send_req(abte_pkg::OP_SEARCH, 32'sd5);
        send_req(abte_pkg::OP_DELETE, 32'sd5);
        // root, duplicate, both signed extremes
        send_req(abte_pkg::OP_INSERT, 32'sd0);
        send_req(abte_pkg::OP_INSERT, 32'sd0);
        send_req(abte_pkg::OP_INSERT, 32'sh7FFF_FFFF);
        send_req(abte_pkg::OP_INSERT, 32'sh8000_0000);
        send_req(abte_pkg::OP_INSERT, -32'sd1);
        send_req(abte_pkg::OP_SEARCH, 32'sh8000_0000);
        send_req(abte_pkg::OP_SEARCH, -32'sd1);
        // unused request code
        send_req(OP_NONE, 32'sd0);
        send_req(OP_NONE, 32'shFFFF_FFFF);
        // root has a left subtree: predecessor moves up
        send_req(abte_pkg::OP_DELETE, 32'sd0);
        // plain leaf
        send_req(abte_pkg::OP_DELETE, 32'sh7FFF_FFFF);
        // ascending run walks the right spine past the last slot
        for (int v = 1; v <= 8; v++)
            send_req(abte_pkg::OP_INSERT, v);
        // node with only a right child: successor moves up
        send_req(abte_pkg::OP_DELETE, 32'sd1);
        send_req(abte_pkg::OP_SEARCH, 32'sd2);
        send_req(abte_pkg::OP_INSERT, 32'shAAAA_AAAA);
        send_req(abte_pkg::OP_INSERT, 32'sh5555_5555);
        hold_until_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // alternate filling and thinning the tree
            grow = ((n / PHASE_LEN) % 2 == 0);
            roll = $urandom_range(0, 99);
            if (roll < (grow ? 55 : 25))
                op = abte_pkg::OP_INSERT;
            else if (roll < (grow ? 75 : 50))
                op = abte_pkg::OP_SEARCH;
            else if (roll < 99)
                op = abte_pkg::OP_DELETE;
            else
                op = OP_NONE;
            send_req(op, draw_key(op));
            if (n % DRAIN_EVERY == DRAIN_EVERY - 1)
                hold_until_drained();
        end
        s_tvalid <= 1'b0;

        while (shadow.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d requests: %0d keys stored, %0d duplicates, %0d full paths, %0d no-ops",
                 shadow.checked, shadow.tally[abte_pkg::OP_INSERT][abte_pkg::STAT_DONE],
                 shadow.tally[abte_pkg::OP_INSERT][abte_pkg::STAT_DUP],
                 shadow.tally[abte_pkg::OP_INSERT][abte_pkg::STAT_FULL],
                 shadow.tally[OP_NONE][abte_pkg::STAT_MISS]);
        $display("search hit/miss %0d/%0d, delete done/miss %0d/%0d, peak %0d of %0d",
                 shadow.tally[abte_pkg::OP_SEARCH][abte_pkg::STAT_DONE],
                 shadow.tally[abte_pkg::OP_SEARCH][abte_pkg::STAT_MISS],
                 shadow.tally[abte_pkg::OP_DELETE][abte_pkg::STAT_DONE],
                 shadow.tally[abte_pkg::OP_DELETE][abte_pkg::STAT_MISS],
                 shadow.peak, SLOTS);
        if (shadow.errors == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("%0d mismatches", shadow.errors);
            $display("FAIL");
        end
        $finish;
    end

endmodule
